### rtl/core/colproj_pkg.sv
// Shared widths, register indexes, reset values and divider stage type.
`timescale 1ns / 1ps

package colproj_pkg;

  localparam int COORD_W = 48;   // Q32.16 coordinate
  localparam int COEF_W  = 32;   // Q2.30 rotation coefficient
  localparam int VEC_W   = 49;   // coordinate difference
  localparam int SUM_W   = 83;   // sum of three coefficient products
  localparam int MAG_W   = 82;   // magnitude of a sum
  localparam int FAC_W   = 48;   // magnitude of the scale factor
  localparam int NUM_W   = 128;  // dividend, low bits of magnitude times factor
  localparam int Q_W     = 61;   // quotient bits kept before clamping
  localparam int CFG_W   = 64;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_ROT_R00_R01   = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROT_R02_R10   = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROT_R11_R12   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROT_R20_R21   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROT_R22_FOCAL = 3'd4;
  localparam logic [IDX_W-1:0] REG_CAM_X         = 3'd5;
  localparam logic [IDX_W-1:0] REG_CAM_Y         = 3'd6;
  localparam logic [IDX_W-1:0] REG_CAM_Z         = 3'd7;

  localparam logic [CFG_W-1:0]   RST_ROT_DIAG  = 64'h4000_0000_0000_0000;
  localparam logic [CFG_W-1:0]   RST_ROT_ZERO  = 64'h0;
  localparam logic [CFG_W-1:0]   RST_ROT_FOCAL = 64'h4000_0000_0001_0000;
  localparam logic [COORD_W-1:0] RST_CAM       = 48'h0000_0001_0000;

  // One request in flight through the divider
  typedef struct packed {
    logic               valid;
    logic               kind;
    logic               fault;
    logic               sgn_x;
    logic               sgn_y;
    logic               ovf_x;
    logic               ovf_y;
    logic [COORD_W-1:0] z;
    logic [MAG_W-1:0]   d;
    logic [MAG_W-1:0]   rem_x;
    logic [MAG_W-1:0]   rem_y;
    logic [Q_W-1:0]     nlo_x;
    logic [Q_W-1:0]     nlo_y;
    logic [Q_W-1:0]     q_x;
    logic [Q_W-1:0]     q_y;
  } div_t;

endpackage

### rtl/core/colproj_div.sv
// Pipelined restoring divider, one quotient bit per stage, two quotients share a divisor.
`timescale 1ns / 1ps

module colproj_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  colproj_pkg::div_t  req_i,
  output colproj_pkg::div_t  rsp_o
);

  colproj_pkg::div_t st_q [colproj_pkg::Q_W+1];

  function automatic colproj_pkg::div_t div_step(input colproj_pkg::div_t s);
    logic [colproj_pkg::MAG_W:0] tx;
    logic [colproj_pkg::MAG_W:0] ty;
    colproj_pkg::div_t r;
    r  = s;
    tx = {s.rem_x, s.nlo_x[colproj_pkg::Q_W-1]};
    ty = {s.rem_y, s.nlo_y[colproj_pkg::Q_W-1]};
    if (tx >= {1'b0, s.d}) begin
      tx = tx - {1'b0, s.d};
      r.q_x = {s.q_x[colproj_pkg::Q_W-2:0], 1'b1};
    end else begin
      r.q_x = {s.q_x[colproj_pkg::Q_W-2:0], 1'b0};
    end
    if (ty >= {1'b0, s.d}) begin
      ty = ty - {1'b0, s.d};
      r.q_y = {s.q_y[colproj_pkg::Q_W-2:0], 1'b1};
    end else begin
      r.q_y = {s.q_y[colproj_pkg::Q_W-2:0], 1'b0};
    end
    r.rem_x = tx[colproj_pkg::MAG_W-1:0];
    r.rem_y = ty[colproj_pkg::MAG_W-1:0];
    r.nlo_x = {s.nlo_x[colproj_pkg::Q_W-2:0], 1'b0};
    r.nlo_y = {s.nlo_y[colproj_pkg::Q_W-2:0], 1'b0};
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= colproj_pkg::Q_W; k++) st_q[k] <= '0;
    end else if (en_i) begin
      st_q[0] <= req_i;
      for (int k = 0; k < colproj_pkg::Q_W; k++) st_q[k+1] <= div_step(st_q[k]);
    end
  end

  assign rsp_o = st_q[colproj_pkg::Q_W];

endmodule

### rtl/core/collinearity_projection.sv
// Top level: collinearity projection between ground and image space, fully pipelined.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------------------
//  in       | in        | in_valid_i / in_stall_o  | kind_i, in_x_i, in_y_i, in_z_i
//  out      | out       | out_valid_o / out_stall_i| out_x_o, out_y_o, out_z_o,
//           |           |                          | divide_fault_o, saturated_o
//  cfg      | in        | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One request per clock unless the output stalls. The pipe is 8 arithmetic stages
// (difference, split products, product merge, row sums, magnitudes, split scale
// products, two merge stages), 62 divider stages (one quotient bit each, 61 bits)
// and the output register. The divider depth sets the latency.
// Reset clears valid bits and loads the configuration defaults (identity
// rotation, unit focal length, camera at 1.0,1.0,1.0).
// A stalled output freezes the whole pipe; in_stall_o follows it in the same cycle.
`timescale 1ns / 1ps

module collinearity_projection (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [colproj_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [colproj_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  kind_i,
  input  logic signed [colproj_pkg::COORD_W-1:0] in_x_i,
  input  logic signed [colproj_pkg::COORD_W-1:0] in_y_i,
  input  logic signed [colproj_pkg::COORD_W-1:0] in_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [colproj_pkg::COORD_W-1:0] out_x_o,
  output logic signed [colproj_pkg::COORD_W-1:0] out_y_o,
  output logic signed [colproj_pkg::COORD_W-1:0] out_z_o,
  output logic                                  divide_fault_o,
  output logic                                  saturated_o
);

  // ---------------------------------------------------------------- config
  logic [colproj_pkg::CFG_W-1:0]          rot_q [5];
  logic signed [colproj_pkg::COORD_W-1:0] cam_x_q, cam_y_q, cam_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= colproj_pkg::RST_ROT_DIAG;
      rot_q[1] <= colproj_pkg::RST_ROT_ZERO;
      rot_q[2] <= colproj_pkg::RST_ROT_DIAG;
      rot_q[3] <= colproj_pkg::RST_ROT_ZERO;
      rot_q[4] <= colproj_pkg::RST_ROT_FOCAL;
      cam_x_q  <= colproj_pkg::RST_CAM;
      cam_y_q  <= colproj_pkg::RST_CAM;
      cam_z_q  <= colproj_pkg::RST_CAM;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        colproj_pkg::REG_ROT_R00_R01:   rot_q[0] <= cfg_data_i;
        colproj_pkg::REG_ROT_R02_R10:   rot_q[1] <= cfg_data_i;
        colproj_pkg::REG_ROT_R11_R12:   rot_q[2] <= cfg_data_i;
        colproj_pkg::REG_ROT_R20_R21:   rot_q[3] <= cfg_data_i;
        colproj_pkg::REG_ROT_R22_FOCAL: rot_q[4] <= cfg_data_i;
        colproj_pkg::REG_CAM_X:         cam_x_q  <= cfg_data_i[colproj_pkg::COORD_W-1:0];
        colproj_pkg::REG_CAM_Y:         cam_y_q  <= cfg_data_i[colproj_pkg::COORD_W-1:0];
        colproj_pkg::REG_CAM_Z:         cam_z_q  <= cfg_data_i[colproj_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Rotation matrix view; the user must keep config static while requests are in flight (not enforced).
  logic signed [colproj_pkg::COEF_W-1:0] rm [3][3];
  logic [31:0]                           focal;

  always_comb begin
    rm[0][0] = rot_q[0][63:32];
    rm[0][1] = rot_q[0][31:0];
    rm[0][2] = rot_q[1][63:32];
    rm[1][0] = rot_q[1][31:0];
    rm[1][1] = rot_q[2][63:32];
    rm[1][2] = rot_q[2][31:0];
    rm[2][0] = rot_q[3][63:32];
    rm[2][1] = rot_q[3][31:0];
    rm[2][2] = rot_q[4][63:32];
    focal    = rot_q[4][31:0];
  end

  // Whole pipe advances together unless the output register holds a stalled result.
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------------------------------------------------------- stage A
  // Operand vector: backward (P - C), forward (x, y, -f). dz kept for the forward scale.
  logic                                 a_valid_q, a_kind_q;
  logic signed [colproj_pkg::VEC_W-1:0] a_v_q [3];
  logic signed [colproj_pkg::VEC_W-1:0] a_dz_q;
  logic [colproj_pkg::COORD_W-1:0]      a_z_q;

  // ---------------------------------------------------------------- stage B
  // Each coefficient product split on the operand: low 24 bits unsigned, high 25 signed.
  logic                                 b_valid_q, b_kind_q;
  logic signed [56:0]                   b_plo_q [3][3];
  logic signed [56:0]                   b_phi_q [3][3];
  logic signed [colproj_pkg::VEC_W-1:0] b_dz_q;
  logic [colproj_pkg::COORD_W-1:0]      b_z_q;

  // ---------------------------------------------------------------- stage C
  logic                                 c_valid_q, c_kind_q;
  logic signed [80:0]                   c_prod_q [3][3];
  logic signed [colproj_pkg::VEC_W-1:0] c_dz_q;
  logic [colproj_pkg::COORD_W-1:0]      c_z_q;

  // ---------------------------------------------------------------- stage D
  // Sums: index 0 numerator x, 1 numerator y, 2 divisor.
  logic                                 d_valid_q, d_kind_q;
  logic signed [colproj_pkg::SUM_W-1:0] d_sum_q [3];
  logic signed [colproj_pkg::VEC_W-1:0] d_dz_q;
  logic [colproj_pkg::COORD_W-1:0]      d_z_q;

  // ---------------------------------------------------------------- stage E
  logic                             e_valid_q, e_kind_q, e_fault_q, e_sgn_x_q, e_sgn_y_q;
  logic [colproj_pkg::MAG_W-1:0]    e_mag_q [2];
  logic [colproj_pkg::MAG_W-1:0]    e_den_q;
  logic [colproj_pkg::FAC_W-1:0]    e_fac_q;
  logic [colproj_pkg::COORD_W-1:0]  e_z_q;

  // ---------------------------------------------------------------- stages F..H
  // |num| * |factor|: 3 x 28-bit num chunks by 2 x 24-bit factor chunks.
  logic                             f_valid_q, f_kind_q, f_fault_q, f_sgn_x_q, f_sgn_y_q;
  logic [51:0]                      f_pp_q [2][3][2];
  logic [colproj_pkg::MAG_W-1:0]    f_den_q;
  logic [colproj_pkg::COORD_W-1:0]  f_z_q;

  logic                             g_valid_q, g_kind_q, g_fault_q, g_sgn_x_q, g_sgn_y_q;
  logic [107:0]                     g_row_q [2][2];
  logic [colproj_pkg::MAG_W-1:0]    g_den_q;
  logic [colproj_pkg::COORD_W-1:0]  g_z_q;

  logic                             h_valid_q, h_kind_q, h_fault_q, h_sgn_x_q, h_sgn_y_q;
  logic [colproj_pkg::NUM_W-1:0]    h_num_q [2];
  logic [colproj_pkg::MAG_W-1:0]    h_den_q;
  logic [colproj_pkg::COORD_W-1:0]  h_z_q;

  // ---------------------------------------------------------------- combinational per stage
  logic signed [colproj_pkg::VEC_W-1:0] a_v_d [3];
  logic signed [colproj_pkg::VEC_W-1:0] a_dz_d;
  logic signed [colproj_pkg::COEF_W-1:0] b_coef [3][3];
  logic signed [56:0]                   b_plo_d [3][3];
  logic signed [56:0]                   b_phi_d [3][3];
  logic signed [80:0]                   c_prod_d [3][3];
  logic signed [colproj_pkg::SUM_W-1:0] d_sum_d [3];
  logic [colproj_pkg::SUM_W-1:0]        e_abs [3];
  logic [colproj_pkg::VEC_W-1:0]        e_dz_abs;
  logic [colproj_pkg::FAC_W-1:0]        e_fac_d;
  logic                                 e_sf;
  logic [83:0]                          f_num_pad [2];
  logic [51:0]                          f_pp_d [2][3][2];
  logic [107:0]                         g_row_d [2][2];
  logic [131:0]                         h_full [2];

  always_comb begin
    a_dz_d = $signed({in_z_i[colproj_pkg::COORD_W-1], in_z_i})
           - $signed({cam_z_q[colproj_pkg::COORD_W-1], cam_z_q});
    if (kind_i) begin
      a_v_d[0] = $signed({in_x_i[colproj_pkg::COORD_W-1], in_x_i});
      a_v_d[1] = $signed({in_y_i[colproj_pkg::COORD_W-1], in_y_i});
      a_v_d[2] = -$signed({17'b0, focal});
    end else begin
      a_v_d[0] = $signed({in_x_i[colproj_pkg::COORD_W-1], in_x_i})
               - $signed({cam_x_q[colproj_pkg::COORD_W-1], cam_x_q});
      a_v_d[1] = $signed({in_y_i[colproj_pkg::COORD_W-1], in_y_i})
               - $signed({cam_y_q[colproj_pkg::COORD_W-1], cam_y_q});
      a_v_d[2] = a_dz_d;
    end

    // Forward kind uses the transposed matrix.
    for (int o = 0; o < 3; o++) begin
      for (int j = 0; j < 3; j++) begin
        b_coef[o][j]  = a_kind_q ? rm[j][o] : rm[o][j];
        b_plo_d[o][j] = b_coef[o][j] * $signed({1'b0, a_v_q[j][23:0]});
        b_phi_d[o][j] = b_coef[o][j] * $signed(a_v_q[j][48:24]);
        c_prod_d[o][j] = $signed({b_phi_q[o][j][56:0], 24'b0})
                       + $signed({{24{b_plo_q[o][j][56]}}, b_plo_q[o][j]});
      end
      d_sum_d[o] = $signed({{2{c_prod_q[o][0][80]}}, c_prod_q[o][0]})
                 + $signed({{2{c_prod_q[o][1][80]}}, c_prod_q[o][1]})
                 + $signed({{2{c_prod_q[o][2][80]}}, c_prod_q[o][2]});
      e_abs[o] = d_sum_q[o][colproj_pkg::SUM_W-1] ? -d_sum_q[o] : d_sum_q[o];
    end

    // Scale: backward by focal length (then negated), forward by z - cz.
    e_dz_abs = d_dz_q[colproj_pkg::VEC_W-1] ? -d_dz_q : d_dz_q;
    e_fac_d  = d_kind_q ? e_dz_abs[colproj_pkg::FAC_W-1:0] : {16'b0, focal};
    e_sf     = d_kind_q & d_dz_q[colproj_pkg::VEC_W-1];

    for (int n = 0; n < 2; n++) begin
      f_num_pad[n] = {2'b0, e_mag_q[n]};
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 2; k++) begin
          f_pp_d[n][c][k] = f_num_pad[n][28*c +: 28] * e_fac_q[24*k +: 24];
        end
      end
      for (int k = 0; k < 2; k++) begin
        g_row_d[n][k] = {56'b0, f_pp_q[n][0][k]} + {28'b0, f_pp_q[n][1][k], 28'b0}
                      + {f_pp_q[n][2][k], 56'b0};
      end
      // Only the low 128 bits of the scaled numerator are kept.
      h_full[n] = {24'b0, g_row_q[n][0]} + {g_row_q[n][1], 24'b0};
    end
  end

  // ---------------------------------------------------------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
      h_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
      f_valid_q <= e_valid_q;
      g_valid_q <= f_valid_q;
      h_valid_q <= g_valid_q;
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_kind_q <= kind_i;
      a_v_q    <= a_v_d;
      a_dz_q   <= a_dz_d;
      a_z_q    <= in_z_i;

      b_kind_q <= a_kind_q;
      b_plo_q  <= b_plo_d;
      b_phi_q  <= b_phi_d;
      b_dz_q   <= a_dz_q;
      b_z_q    <= a_z_q;

      c_kind_q <= b_kind_q;
      c_prod_q <= c_prod_d;
      c_dz_q   <= b_dz_q;
      c_z_q    <= b_z_q;

      d_kind_q <= c_kind_q;
      d_sum_q  <= d_sum_d;
      d_dz_q   <= c_dz_q;
      d_z_q    <= c_z_q;

      e_kind_q   <= d_kind_q;
      e_fault_q  <= (d_sum_q[2] == '0);
      e_sgn_x_q  <= d_sum_q[0][colproj_pkg::SUM_W-1] ^ d_sum_q[2][colproj_pkg::SUM_W-1]
                  ^ e_sf ^ !d_kind_q;
      e_sgn_y_q  <= d_sum_q[1][colproj_pkg::SUM_W-1] ^ d_sum_q[2][colproj_pkg::SUM_W-1]
                  ^ e_sf ^ !d_kind_q;
      e_mag_q[0] <= e_abs[0][colproj_pkg::MAG_W-1:0];
      e_mag_q[1] <= e_abs[1][colproj_pkg::MAG_W-1:0];
      e_den_q    <= e_abs[2][colproj_pkg::MAG_W-1:0];
      e_fac_q    <= e_fac_d;
      e_z_q      <= d_z_q;

      f_kind_q  <= e_kind_q;
      f_fault_q <= e_fault_q;
      f_sgn_x_q <= e_sgn_x_q;
      f_sgn_y_q <= e_sgn_y_q;
      f_pp_q    <= f_pp_d;
      f_den_q   <= e_den_q;
      f_z_q     <= e_z_q;

      g_kind_q  <= f_kind_q;
      g_fault_q <= f_fault_q;
      g_sgn_x_q <= f_sgn_x_q;
      g_sgn_y_q <= f_sgn_y_q;
      g_row_q   <= g_row_d;
      g_den_q   <= f_den_q;
      g_z_q     <= f_z_q;

      h_kind_q   <= g_kind_q;
      h_fault_q  <= g_fault_q;
      h_sgn_x_q  <= g_sgn_x_q;
      h_sgn_y_q  <= g_sgn_y_q;
      h_num_q[0] <= h_full[0][colproj_pkg::NUM_W-1:0];
      h_num_q[1] <= h_full[1][colproj_pkg::NUM_W-1:0];
      h_den_q    <= g_den_q;
      h_z_q      <= g_z_q;
    end
  end

  // ---------------------------------------------------------------- divider
  // A quotient of 2^61 or more is caught up front (num >= den << 61) and clamped
  // later; otherwise num >> 61 is already below den and seeds the remainder.
  colproj_pkg::div_t div_req, div_rsp;

  always_comb begin
    div_req       = '0;
    div_req.valid = h_valid_q;
    div_req.kind  = h_kind_q;
    div_req.fault = h_fault_q;
    div_req.sgn_x = h_sgn_x_q;
    div_req.sgn_y = h_sgn_y_q;
    div_req.ovf_x = {15'b0, h_num_q[0]} >= {h_den_q, 61'b0};
    div_req.ovf_y = {15'b0, h_num_q[1]} >= {h_den_q, 61'b0};
    div_req.z     = h_z_q;
    div_req.d     = h_den_q;
    div_req.rem_x = {15'b0, h_num_q[0][colproj_pkg::NUM_W-1:colproj_pkg::Q_W]};
    div_req.rem_y = {15'b0, h_num_q[1][colproj_pkg::NUM_W-1:colproj_pkg::Q_W]};
    div_req.nlo_x = h_num_q[0][colproj_pkg::Q_W-1:0];
    div_req.nlo_y = h_num_q[1][colproj_pkg::Q_W-1:0];
  end

  colproj_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- finish
  // Clamp quotient to 2^60, apply sign, add offset (camera for forward, zero for backward), saturate to 48 bits.
  // Result: {saturated, value}.
  function automatic logic [colproj_pkg::COORD_W:0] finish_fn(
    input logic                                  ovf,
    input logic [colproj_pkg::Q_W-1:0]           q,
    input logic                                  sgn,
    input logic signed [colproj_pkg::COORD_W-1:0] off
  );
    logic [colproj_pkg::Q_W-1:0] m;
    logic signed [62:0]          v;
    logic signed [62:0]          vmax;
    logic signed [62:0]          vmin;
    m    = (ovf || q > {1'b1, 60'b0}) ? {1'b1, 60'b0} : q;
    v    = sgn ? -$signed({2'b0, m}) : $signed({2'b0, m});
    v    = v + $signed({{15{off[colproj_pkg::COORD_W-1]}}, off});
    vmax = $signed({16'b0, 47'h7FFF_FFFF_FFFF});
    vmin = -$signed({15'b0, 1'b1, 47'b0});
    if (v > vmax) begin
      return {1'b1, 1'b0, {(colproj_pkg::COORD_W-1){1'b1}}};
    end else if (v < vmin) begin
      return {1'b1, 1'b1, {(colproj_pkg::COORD_W-1){1'b0}}};
    end
    return {1'b0, v[colproj_pkg::COORD_W-1:0]};
  endfunction

  logic [colproj_pkg::COORD_W:0]          fx, fy;
  logic signed [colproj_pkg::COORD_W-1:0] off_x, off_y;

  always_comb begin
    off_x = div_rsp.kind ? cam_x_q : '0;
    off_y = div_rsp.kind ? cam_y_q : '0;
    fx    = finish_fn(div_rsp.ovf_x, div_rsp.q_x, div_rsp.sgn_x, off_x);
    fy    = finish_fn(div_rsp.ovf_y, div_rsp.q_y, div_rsp.sgn_y, off_y);
  end

  logic signed [colproj_pkg::COORD_W-1:0] out_x_q, out_y_q, out_z_q;
  logic                                   fault_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_rsp.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (div_rsp.fault) begin
        out_x_q <= '0;
        out_y_q <= '0;
        out_z_q <= '0;
        fault_q <= 1'b1;
        sat_q   <= 1'b0;
      end else begin
        out_x_q <= fx[colproj_pkg::COORD_W-1:0];
        out_y_q <= fy[colproj_pkg::COORD_W-1:0];
        out_z_q <= div_rsp.kind ? div_rsp.z : '0;
        fault_q <= 1'b0;
        sat_q   <= fx[colproj_pkg::COORD_W] | fy[colproj_pkg::COORD_W];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_x_o        = out_x_q;
  assign out_y_o        = out_y_q;
  assign out_z_o        = out_z_q;
  assign divide_fault_o = fault_q;
  assign saturated_o    = sat_q;

endmodule

### dv/tb_top.sv
// Self-checking testbench for the collinearity projection block.
`timescale 1ns / 1ps

module tb_top;
  import colproj_pkg::*;

  // One request into the block and the projection it should give
  typedef struct {
    logic               kind;
    logic [COORD_W-1:0] x, y, z;
  } point_t;

  typedef struct {
    logic [COORD_W-1:0] x, y, z;
    logic               fault, sat;
  } proj_t;

  localparam logic KIND_BACKWARD = 1'b0;
  localparam logic KIND_FORWARD  = 1'b1;
  localparam int   DRAIN_CYCLES  = 80;    // pipe is 71 deep
  localparam int   WATCHDOG_MAX  = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic signed [COORD_W-1:0] in_x = '0, in_y = '0, in_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_x, out_y, out_z;
  logic divide_fault, saturated;

  always #5 clk_i = ~clk_i;

  collinearity_projection dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .in_x_i(in_x), .in_y_i(in_y), .in_z_i(in_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_x_o(out_x), .out_y_o(out_y), .out_z_o(out_z),
    .divide_fault_o(divide_fault), .saturated_o(saturated)
  );

  // Mirror of the register file
  logic [CFG_W-1:0] regs_m [8];
  point_t pending_points[$];
  proj_t  expected_projs[$];
  int errors = 0, n_sent = 0, n_checked = 0, n_faults = 0, n_sats = 0;
  int n_phases = 0;
  bit any_accept;

  // Sign-extend one 32-bit word of a rotation register
  function automatic logic signed [127:0] coef(int idx, bit upper);
    logic [31:0] w;
    w = upper ? regs_m[idx][63:32] : regs_m[idx][31:0];
    return {{96{w[31]}}, w};
  endfunction

  function automatic logic signed [127:0] sx48(logic [COORD_W-1:0] v);
    return {{80{v[47]}}, v};
  endfunction

  // offset + sign * trunc(|num * fac| / |den|), clamped to 48 bits; {sat, value}
  function automatic logic [48:0] scale_quot(logic signed [127:0] num,
      logic signed [127:0] fac, logic signed [127:0] den, bit negate,
      logic signed [127:0] offset);
    logic [127:0] an, af, ad, prod, q;
    logic [63:0] m;
    logic signed [63:0] v;
    bit sgn;
    sgn = num[127] ^ den[127] ^ fac[127] ^ negate;
    an = num[127] ? -num : num;
    af = fac[127] ? -fac : fac;
    ad = den[127] ? -den : den;
    prod = an * af;               // low 128 bits only, as the block keeps
    q = prod / ad;
    m = (q > (128'd1 << 60)) ? (64'd1 << 60) : q[63:0];
    v = (sgn ? -m : m) + offset[63:0];
    if (v < -(64'sd1 <<< 47)) return {1'b1, 48'h8000_0000_0000};
    if (v > (64'sd1 <<< 47) - 1) return {1'b1, 48'h7FFF_FFFF_FFFF};
    return {1'b0, v[47:0]};
  endfunction

  function automatic proj_t project(point_t p);
    logic signed [127:0] r00, r01, r02, r10, r11, r12, r20, r21, r22, f;
    logic signed [127:0] cx, cy, cz, dx, dy, dz, nx, ny, den;
    logic [48:0] rx, ry;
    proj_t o;
    r00 = coef(0, 1); r01 = coef(0, 0); r02 = coef(1, 1);
    r10 = coef(1, 0); r11 = coef(2, 1); r12 = coef(2, 0);
    r20 = coef(3, 1); r21 = coef(3, 0); r22 = coef(4, 1);
    f = {96'd0, regs_m[4][31:0]};
    cx = sx48(regs_m[5][47:0]); cy = sx48(regs_m[6][47:0]); cz = sx48(regs_m[7][47:0]);
    dz = sx48(p.z) - cz;
    if (p.kind == KIND_BACKWARD) begin
      dx = sx48(p.x) - cx;
      dy = sx48(p.y) - cy;
      den = r20 * dx + r21 * dy + r22 * dz;
      nx = r00 * dx + r01 * dy + r02 * dz;
      ny = r10 * dx + r11 * dy + r12 * dz;
      rx = scale_quot(nx, f, den, 1'b1, '0);
      ry = scale_quot(ny, f, den, 1'b1, '0);
      o.z = '0;
    end else begin
      den = r02 * sx48(p.x) + r12 * sx48(p.y) - r22 * f;
      nx = r00 * sx48(p.x) + r10 * sx48(p.y) - r20 * f;
      ny = r01 * sx48(p.x) + r11 * sx48(p.y) - r21 * f;
      rx = scale_quot(nx, dz, den, 1'b0, cx);
      ry = scale_quot(ny, dz, den, 1'b0, cy);
      o.z = p.z;
    end
    if (den == 0) begin
      o = '{x: '0, y: '0, z: '0, fault: 1'b1, sat: 1'b0};
    end else begin
      o.x = rx[47:0];
      o.y = ry[47:0];
      o.fault = 1'b0;
      o.sat = rx[48] | ry[48];
    end
    return o;
  endfunction

  // Coordinate mix: small values near zero, full range, and extremes
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 48'h7FFF_FFFF_FFFF;
      1: return 48'h8000_0000_0000;
      2, 3, 4: return 48'({$urandom, $urandom});
      default: return {{28{1'b0}}, 20'($urandom)} - 48'h8_0000;
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.kind = 1'($urandom);
    p.x = rand_coord();
    p.y = rand_coord();
    p.z = ($urandom_range(0, 15) == 0) ? regs_m[7][47:0] : rand_coord();
    return p;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    regs_m[idx] = (idx >= REG_CAM_X) ? {16'd0, data[47:0]} : data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Sampled between edges so the driver's updates have settled
  task automatic wait_idle();
    forever begin
      @(negedge clk_i);
      if (pending_points.size() == 0 && !in_valid && expected_projs.size() == 0) break;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_point(logic k, logic [47:0] x, logic [47:0] y, logic [47:0] z);
    pending_points.push_back('{kind: k, x: x, y: y, z: z});
  endtask

  // Driver: bursts of requests with random gaps between them
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    point_t p;
    if (in_valid && !in_stall) begin
      expected_projs.push_back(project('{kind: kind, x: in_x, y: in_y, z: in_z}));
      n_sent++;
    end
    if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        p = pending_points.pop_front();
        kind <= p.kind;
        in_x <= p.x;
        in_y <= p.y;
        in_z <= p.z;
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: randomly redrawn stall pattern; one long hold-off once 400 requests are sent
  int rx_cycle = 0, stall_mode = 0, hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (!hold_done && n_sent >= 400) begin
      hold_done = 1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= rx_cycle[0];
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Monitor: compare each result with the oldest expected projection
  always @(posedge clk_i) begin
    proj_t e;
    if (out_valid && !out_stall) begin
      if (expected_projs.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h", $time, out_x, out_y);
        errors++;
      end else begin
        e = expected_projs.pop_front();
        n_checked++;
        if (e.fault) n_faults++;
        if (e.sat) n_sats++;
        if (out_x !== e.x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.x, out_x);
          errors++;
        end
        if (out_y !== e.y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.y, out_y);
          errors++;
        end
        if (out_z !== e.z) begin
          $display("%0t: out_z expected %h actual %h", $time, e.z, out_z);
          errors++;
        end
        if (divide_fault !== e.fault) begin
          $display("%0t: divide_fault expected %b actual %b", $time, e.fault, divide_fault);
          errors++;
        end
        if (saturated !== e.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, e.sat, saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    any_accept = (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we;
    idle_cycles = any_accept ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("watchdog expired, %0d results outstanding", expected_projs.size());
      $display("collinearity_projection regression: fail");
      $finish;
    end
  end

  initial begin
    logic [63:0] c, s;
    regs_m[0] = RST_ROT_DIAG;  regs_m[1] = RST_ROT_ZERO;
    regs_m[2] = RST_ROT_DIAG;  regs_m[3] = RST_ROT_ZERO;
    regs_m[4] = RST_ROT_FOCAL;
    regs_m[5] = {16'd0, RST_CAM}; regs_m[6] = {16'd0, RST_CAM}; regs_m[7] = {16'd0, RST_CAM};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset orientation, field extremes, both kinds
    add_point(KIND_BACKWARD, 48'h0, 48'h0, 48'h0);
    add_point(KIND_BACKWARD, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h0);
    add_point(KIND_BACKWARD, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
    add_point(KIND_BACKWARD, 48'h5, 48'h7, 48'h1_0000);               // height at camera: fault
    add_point(KIND_BACKWARD, 48'h4000_0000_0000, 48'h1, 48'h1_0001);  // tiny divisor: clipped
    add_point(KIND_BACKWARD, 48'hC000_0000_0000, 48'h3_0000, 48'h0_FFFF);
    add_point(KIND_BACKWARD, 48'h2_0000, 48'hFFFF_FFFF_0000, 48'h8000_0000_0000);
    add_point(KIND_FORWARD, 48'h0, 48'h0, 48'h0);
    add_point(KIND_FORWARD, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
    add_point(KIND_FORWARD, 48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000);
    add_point(KIND_FORWARD, 48'h1_8000, 48'hFFFF_FFFE_8000, 48'h10_0000);
    add_point(KIND_FORWARD, 48'hFFFF_FFFF_FFFF, 48'h1, 48'h1_0000);
    add_point(KIND_FORWARD, 48'h0_0001, 48'h0, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 300; i++) pending_points.push_back(rand_point());

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      n_phases++;
      case (ph)
        0, 1: begin
          // plausible small rotation about z, camera well above ground
          c = 64'h3F00_0000 + $urandom_range(0, 32'h00FF_FFFF);
          s = $urandom_range(0, 32'h0FFF_FFFF);
          write_reg(REG_ROT_R00_R01, {c[31:0], s[31:0]});
          write_reg(REG_ROT_R02_R10, {32'd0, -s[31:0]});
          write_reg(REG_ROT_R11_R12, {c[31:0], 32'($urandom_range(0, 32'h00FF_FFFF))});
          write_reg(REG_ROT_R20_R21, {32'($urandom_range(0, 32'h00FF_FFFF)), 32'd0});
          write_reg(REG_ROT_R22_FOCAL, {32'h4000_0000, 32'($urandom_range(1, 32'h0400_0000))});
          write_reg(REG_CAM_X, {$urandom, $urandom} & 64'hFFFF_0000_00FF_FFFF);
          write_reg(REG_CAM_Y, {$urandom, 32'($urandom_range(0, 32'h00FF_FFFF))});
          write_reg(REG_CAM_Z, 64'h3E8_0000 + $urandom_range(0, 32'hFFFF));
        end
        2, 3: begin
          for (int r = 0; r < 8; r++) write_reg(IDX_W'(r), {$urandom, $urandom});
        end
        4: begin
          // coefficient and camera x/y extremes; focal zero, camera z zero
          write_reg(REG_ROT_R00_R01, 64'h7FFF_FFFF_7FFF_FFFF);
          write_reg(REG_ROT_R02_R10, 64'h7FFF_FFFF_8000_0000);
          write_reg(REG_ROT_R11_R12, 64'h8000_0000_7FFF_FFFF);
          write_reg(REG_ROT_R20_R21, 64'h8000_0000_8000_0000);
          write_reg(REG_ROT_R22_FOCAL, 64'h7FFF_FFFF_0000_0000);
          write_reg(REG_CAM_X, 64'hFFFF_7FFF_FFFF_FFFF);
          write_reg(REG_CAM_Y, 64'h0000_8000_0000_0000);
          write_reg(REG_CAM_Z, 64'h0000_0000_0000_0000);
        end
        default: begin
          // degenerate orientation: rotation zero but for two -1 LSB coefficients, maximum focal length
          write_reg(REG_ROT_R00_R01, 64'h0);
          write_reg(REG_ROT_R02_R10, 64'hFFFF_FFFF_0000_0000);
          write_reg(REG_ROT_R11_R12, 64'h0);
          write_reg(REG_ROT_R20_R21, 64'h0000_0000_FFFF_FFFF);
          write_reg(REG_ROT_R22_FOCAL, 64'h0000_0000_FFFF_FFFF);
          write_reg(REG_CAM_X, 64'h0);
          write_reg(REG_CAM_Y, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(REG_CAM_Z, 64'h8000_0000_0000);
        end
      endcase
      add_point(KIND_FORWARD, 48'h0, 48'h0, 48'h1);
      add_point(KIND_BACKWARD, regs_m[5][47:0], regs_m[6][47:0], regs_m[7][47:0]);
      for (int i = 0; i < 260; i++) pending_points.push_back(rand_point());
    end

    wait_idle();
    $display("checked %0d of %0d projections over %0d orientations", n_checked, n_sent,
             n_phases + 1);
    $display("divisor faults %0d, clipped results %0d, mismatches %0d", n_faults, n_sats,
             errors);
    if (errors == 0) begin
      $display("collinearity_projection regression: pass");
    end else begin
      $display("collinearity_projection regression: fail");
    end
    $finish;
  end

endmodule
